@@ design/asgd_pkg.sv @@
// Shared types and constants for the accelerometer shake gesture detector.
`default_nettype none
package asgd_pkg;

  // Field widths
  localparam int unsigned AccelW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ThrW    = 34;
  localparam int unsigned MsW     = 16;
  localparam int unsigned CountW  = 4;
  localparam int unsigned MagW    = 34;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 34;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 8;

  // Register indexes
  localparam logic [CfgAddrW-1:0] RegThreshold = 3'd0;
  localparam logic [CfgAddrW-1:0] RegDebounce  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegWindow    = 3'd2;
  localparam logic [CfgAddrW-1:0] RegJolts     = 3'd3;
  localparam logic [CfgAddrW-1:0] RegHoldoff   = 3'd4;

  // Register reset values: threshold is (1.2 g * 4096 counts/g)^2, rounded down
  localparam logic [ThrW-1:0]   ThresholdRst = 34'd24159191;
  localparam logic [MsW-1:0]    DebounceRst  = 16'd100;
  localparam logic [MsW-1:0]    WindowRst    = 16'd1500;
  localparam logic [CountW-1:0] JoltsRst     = 4'd8;
  localparam logic [MsW-1:0]    HoldoffRst   = 16'd500;

  typedef struct packed {
    logic [ThrW-1:0]   threshold_sq;
    logic [MsW-1:0]    debounce_ms;
    logic [MsW-1:0]    window_ms;
    logic [CountW-1:0] jolts_needed;
    logic [MsW-1:0]    holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [AccelW-1:0] accel_x;
    logic signed [AccelW-1:0] accel_y;
    logic signed [AccelW-1:0] accel_z;
    logic [TimeW-1:0]         time_ms;
  } sample_t;

  typedef struct packed {
    logic signed [AccelW-1:0] x;
    logic signed [AccelW-1:0] y;
    logic signed [AccelW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic              sample_ignored;
    logic [CountW-1:0] jolt_count;
    logic              jolt_counted;
    logic              sequence_timeout;
    logic              shake_detected;
  } result_t;

endpackage
`default_nettype wire

@@ design/asgd_cfg.sv @@
// Configuration register file with index decode and width masking.
`default_nettype none
module asgd_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [asgd_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [asgd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output asgd_pkg::cfg_t                      cfg_o
);

  asgd_pkg::cfg_t cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_sq <= asgd_pkg::ThresholdRst;
      cfg_q.debounce_ms  <= asgd_pkg::DebounceRst;
      cfg_q.window_ms    <= asgd_pkg::WindowRst;
      cfg_q.jolts_needed <= asgd_pkg::JoltsRst;
      cfg_q.holdoff_ms   <= asgd_pkg::HoldoffRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        asgd_pkg::RegThreshold: cfg_q.threshold_sq <= cfg_wdata_i[asgd_pkg::ThrW-1:0];
        asgd_pkg::RegDebounce:  cfg_q.debounce_ms  <= cfg_wdata_i[asgd_pkg::MsW-1:0];
        asgd_pkg::RegWindow:    cfg_q.window_ms    <= cfg_wdata_i[asgd_pkg::MsW-1:0];
        asgd_pkg::RegJolts:     cfg_q.jolts_needed <= cfg_wdata_i[asgd_pkg::CountW-1:0];
        asgd_pkg::RegHoldoff:   cfg_q.holdoff_ms   <= cfg_wdata_i[asgd_pkg::MsW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ design/asgd_mag.sv @@
// Squared change magnitude between the current and the previous sample.
`default_nettype none
module asgd_mag (
  input  wire asgd_pkg::vec_t              cur_i,
  input  wire asgd_pkg::vec_t              prev_i,
  output logic [asgd_pkg::MagW-1:0]        mag_o
);

  localparam int unsigned DiffW = asgd_pkg::AccelW + 1;
  localparam int unsigned SqW   = 2 * asgd_pkg::AccelW;

  logic signed [DiffW-1:0] dx, dy, dz;
  logic [asgd_pkg::AccelW-1:0] ax, ay, az;
  logic [SqW-1:0] sx, sy, sz;

  // 17-bit differences; magnitude always fits 16 bits unsigned
  assign dx = {cur_i.x[asgd_pkg::AccelW-1], cur_i.x} - {prev_i.x[asgd_pkg::AccelW-1], prev_i.x};
  assign dy = {cur_i.y[asgd_pkg::AccelW-1], cur_i.y} - {prev_i.y[asgd_pkg::AccelW-1], prev_i.y};
  assign dz = {cur_i.z[asgd_pkg::AccelW-1], cur_i.z} - {prev_i.z[asgd_pkg::AccelW-1], prev_i.z};

  always_comb begin
    ax = dx[DiffW-1] ? asgd_pkg::AccelW'(-dx) : dx[asgd_pkg::AccelW-1:0];
    ay = dy[DiffW-1] ? asgd_pkg::AccelW'(-dy) : dy[asgd_pkg::AccelW-1:0];
    az = dz[DiffW-1] ? asgd_pkg::AccelW'(-dz) : dz[asgd_pkg::AccelW-1:0];
  end

  // Three parallel 16x16 squares and their sum
  assign sx = ax * ax;
  assign sy = ay * ay;
  assign sz = az * az;
  assign mag_o = asgd_pkg::MagW'(sx) + asgd_pkg::MagW'(sy) + asgd_pkg::MagW'(sz);

endmodule
`default_nettype wire

@@ design/asgd_ctrl.sv @@
// Jolt debounce, window, detection and hold-off state with per-sample decision.
`default_nettype none
module asgd_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire asgd_pkg::sample_t           sample_i,
  input  wire logic [asgd_pkg::MagW-1:0]   mag_i,
  input  wire asgd_pkg::cfg_t              cfg_i,
  output asgd_pkg::vec_t                   prev_o,
  output asgd_pkg::result_t                res_o
);

  localparam int unsigned TW = asgd_pkg::TimeW;
  localparam int unsigned CW = asgd_pkg::CountW;

  asgd_pkg::vec_t prev_q, prev_d;
  logic           have_prev_q, have_prev_d;
  logic [CW-1:0]  count_q, count_d;
  logic [TW-1:0]  win_start_q, win_start_d;
  logic [TW-1:0]  last_jolt_q, last_jolt_d;
  logic [TW-1:0]  hold_start_q, hold_start_d;
  logic           hold_act_q, hold_act_d;

  logic [CW-1:0]  needed;
  logic [TW-1:0]  t, hold_el, jolt_el, win_el;
  logic [CW-1:0]  count_j;
  logic [TW-1:0]  win_start_j;
  logic           in_holdoff, jolt;

  assign t       = sample_i.time_ms;
  assign needed  = (cfg_i.jolts_needed == '0) ? CW'(1) : cfg_i.jolts_needed;
  assign hold_el = t - hold_start_q;
  assign jolt_el = t - last_jolt_q;
  assign in_holdoff = hold_act_q && (hold_el < TW'(cfg_i.holdoff_ms));
  assign jolt    = (mag_i > cfg_i.threshold_sq) && (jolt_el > TW'(cfg_i.debounce_ms));

  // Count and window start after this sample's jolt, before detect/timeout
  assign count_j     = jolt ? count_q + CW'(1) : count_q;
  assign win_start_j = (jolt && count_q == '0) ? t : win_start_q;
  assign win_el      = t - win_start_j;

  // Per-sample decision
  always_comb begin
    prev_d       = prev_q;
    have_prev_d  = have_prev_q;
    count_d      = count_q;
    win_start_d  = win_start_q;
    last_jolt_d  = last_jolt_q;
    hold_start_d = hold_start_q;
    hold_act_d   = hold_act_q;
    res_o        = '0;
    if (!have_prev_q) begin
      have_prev_d = 1'b1;
      prev_d.x    = sample_i.accel_x;
      prev_d.y    = sample_i.accel_y;
      prev_d.z    = sample_i.accel_z;
      res_o.sample_ignored = 1'b1;
    end else if (in_holdoff) begin
      res_o.sample_ignored = 1'b1;
    end else begin
      hold_act_d  = 1'b0;
      prev_d.x    = sample_i.accel_x;
      prev_d.y    = sample_i.accel_y;
      prev_d.z    = sample_i.accel_z;
      count_d     = count_j;
      win_start_d = win_start_j;
      if (jolt) begin
        last_jolt_d = t;
        res_o.jolt_counted = 1'b1;
      end
      if (count_j >= needed && win_el <= TW'(cfg_i.window_ms)) begin
        res_o.shake_detected = 1'b1;
        count_d      = '0;
        win_start_d  = '0;
        hold_act_d   = 1'b1;
        hold_start_d = t;
      end else if (win_el > TW'(cfg_i.window_ms) && count_j != '0) begin
        res_o.sequence_timeout = 1'b1;
        count_d     = '0;
        win_start_d = '0;
      end
    end
    res_o.jolt_count = count_d;
  end

  // State registers, updated once per processed sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      have_prev_q  <= 1'b0;
      count_q      <= '0;
      win_start_q  <= '0;
      last_jolt_q  <= '0;
      hold_start_q <= '0;
      hold_act_q   <= 1'b0;
    end else if (step_i) begin
      prev_q       <= prev_d;
      have_prev_q  <= have_prev_d;
      count_q      <= count_d;
      win_start_q  <= win_start_d;
      last_jolt_q  <= last_jolt_d;
      hold_start_q <= hold_start_d;
      hold_act_q   <= hold_act_d;
    end
  end

  assign prev_o = prev_q;

  // A detection always leaves an empty count
  a_det_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.shake_detected |=> count_q == '0)
    else $error("count not cleared after detection");

  // During hold-off no jolts are pending
  a_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_act_q |-> count_q == '0 && win_start_q == '0)
    else $error("jolts pending during hold-off");

  // Hold-off can only follow a stored first sample
  a_hold_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_act_q |-> have_prev_q)
    else $error("hold-off without a previous sample");

endmodule
`default_nettype wire

@@ design/accel_shake_gesture_detector_unit.sv @@
// Top level: stream ports, input and result registers, config and datapath.
// Path: a sample passes the input register, then the result register, before its result
//   is offered on the result stream.
// Throughput: one sample per cycle unless stalled; the state update closes between the two registers.
// Reset: rst_ni clears all state and loads the register defaults; samples are
//   accepted from the first cycle after reset is released.
`default_nettype none
module accel_shake_gesture_detector_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input stream
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32], time_ms[79:48]
  input  wire logic [asgd_pkg::InDataW-1:0]    s_axis_tdata_i,
  // Result stream
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // tdata: shake_detected[0], sequence_timeout[1], jolt_counted[2],
  //        jolt_count[6:3], sample_ignored[7]
  output logic [asgd_pkg::OutDataW-1:0]        m_axis_tdata_o,
  // Configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [asgd_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire logic [asgd_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int unsigned AW = asgd_pkg::AccelW;

  asgd_pkg::cfg_t    cfg;
  asgd_pkg::sample_t in_q;
  logic              in_valid_q;
  asgd_pkg::result_t out_q, res;
  logic              out_valid_q;
  asgd_pkg::vec_t    prev, cur;
  logic [asgd_pkg::MagW-1:0] mag;
  logic              advance;

  // Move a sample from the input register into the result register
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q.accel_x <= s_axis_tdata_i[AW-1:0];
      in_q.accel_y <= s_axis_tdata_i[2*AW-1:AW];
      in_q.accel_z <= s_axis_tdata_i[3*AW-1:2*AW];
      in_q.time_ms <= s_axis_tdata_i[3*AW+asgd_pkg::TimeW-1:3*AW];
    end
  end

  asgd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign cur.x = in_q.accel_x;
  assign cur.y = in_q.accel_y;
  assign cur.z = in_q.accel_z;

  asgd_mag u_mag (
    .cur_i  (cur),
    .prev_i (prev),
    .mag_o  (mag)
  );

  asgd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (in_q),
    .mag_i    (mag),
    .cfg_i    (cfg),
    .prev_o   (prev),
    .res_o    (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.sample_ignored, out_q.jolt_count, out_q.jolt_counted,
                            out_q.sequence_timeout, out_q.shake_detected};

  // A stalled input sample is neither lost nor changed
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("input sample lost while stalled");

  // Detection and timeout never occur together, and ignored samples count no jolt and detect nothing
  a_res_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.shake_detected && out_q.sequence_timeout) &&
                    !(out_q.sample_ignored && (out_q.jolt_counted || out_q.shake_detected)))
    else $error("inconsistent result flags");

  // A result not taken stays registered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_q))
    else $error("result dropped while stalled");

endmodule
`default_nettype wire
